@@ rtl/sle_pkg.sv @@
// shared types, codes and key decode for the serial line editor
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

   localparam int LINE_CAPACITY_DEF = 64;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 6;
   localparam int EVENT_W = 5;
   localparam int KEY_W   = 5;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [EVENT_W-1:0] event_type;
   typedef logic [KEY_W-1:0]   key_type;

   // received bytes
   localparam byte_type CH_CTRL_A  = 8'h01;
   localparam byte_type CH_CTRL_B  = 8'h02;
   localparam byte_type CH_CTRL_C  = 8'h03;
   localparam byte_type CH_CTRL_D  = 8'h04;
   localparam byte_type CH_CTRL_E  = 8'h05;
   localparam byte_type CH_CTRL_F  = 8'h06;
   localparam byte_type CH_BS      = 8'h08;
   localparam byte_type CH_LF      = 8'h0A;
   localparam byte_type CH_CTRL_K  = 8'h0B;
   localparam byte_type CH_CTRL_L  = 8'h0C;
   localparam byte_type CH_CR      = 8'h0D;
   localparam byte_type CH_CTRL_N  = 8'h0E;
   localparam byte_type CH_CTRL_P  = 8'h10;
   localparam byte_type CH_CTRL_R  = 8'h12;
   localparam byte_type CH_CTRL_T  = 8'h14;
   localparam byte_type CH_CTRL_U  = 8'h15;
   localparam byte_type CH_CTRL_W  = 8'h17;
   localparam byte_type CH_ESC     = 8'h1B;
   localparam byte_type CH_SPACE   = 8'h20;
   localparam byte_type CH_DIGIT_1 = 8'h31;
   localparam byte_type CH_DIGIT_3 = 8'h33;
   localparam byte_type CH_DIGIT_4 = 8'h34;
   localparam byte_type CH_UPPER_A = 8'h41;
   localparam byte_type CH_UPPER_B = 8'h42;
   localparam byte_type CH_UPPER_C = 8'h43;
   localparam byte_type CH_UPPER_D = 8'h44;
   localparam byte_type CH_UPPER_F = 8'h46;
   localparam byte_type CH_UPPER_H = 8'h48;
   localparam byte_type CH_LBRACKET = 8'h5B;
   localparam byte_type CH_TILDE   = 8'h7E;
   localparam byte_type CH_DEL     = 8'h7F;

   // event codes
   localparam event_type EV_NONE      = 5'd0;
   localparam event_type EV_EMPTY     = 5'd1;
   localparam event_type EV_COMMAND   = 5'd2;
   localparam event_type EV_CHANGED   = 5'd3;
   localparam event_type EV_MOVED     = 5'd4;
   localparam event_type EV_HOME      = 5'd5;
   localparam event_type EV_END       = 5'd6;
   localparam event_type EV_PREV      = 5'd7;
   localparam event_type EV_NEXT      = 5'd8;
   localparam event_type EV_INTR      = 5'd9;
   localparam event_type EV_EOF       = 5'd10;
   localparam event_type EV_KILL      = 5'd11;
   localparam event_type EV_CLEAR     = 5'd12;
   localparam event_type EV_REDRAW    = 5'd13;
   localparam event_type EV_SWAP      = 5'd14;
   localparam event_type EV_WORD      = 5'd15;
   localparam event_type EV_CLEARLINE = 5'd16;

   // decoded keys
   localparam key_type KEY_NONE      = 5'd0;
   localparam key_type KEY_ENTER     = 5'd1;
   localparam key_type KEY_BS        = 5'd2;
   localparam key_type KEY_DEL       = 5'd3;
   localparam key_type KEY_LEFT      = 5'd4;
   localparam key_type KEY_RIGHT     = 5'd5;
   localparam key_type KEY_HOME      = 5'd6;
   localparam key_type KEY_END       = 5'd7;
   localparam key_type KEY_UP        = 5'd8;
   localparam key_type KEY_DOWN      = 5'd9;
   localparam key_type KEY_INTR      = 5'd10;
   localparam key_type KEY_CTRLD     = 5'd11;
   localparam key_type KEY_KILL      = 5'd12;
   localparam key_type KEY_CLEAR     = 5'd13;
   localparam key_type KEY_REDRAW    = 5'd14;
   localparam key_type KEY_SWAP      = 5'd15;
   localparam key_type KEY_WORD      = 5'd16;
   localparam key_type KEY_CLEARLINE = 5'd17;
   localparam key_type KEY_CHAR      = 5'd18;

   // datapath selects
   typedef logic [2:0] ptr_sel_type;
   localparam ptr_sel_type PTR_HOLD    = 3'd0;
   localparam ptr_sel_type PTR_ZERO    = 3'd1;
   localparam ptr_sel_type PTR_CUR     = 3'd2;
   localparam ptr_sel_type PTR_CUR_INC = 3'd3;
   localparam ptr_sel_type PTR_CUR_DEC = 3'd4;
   localparam ptr_sel_type PTR_LEN_DEC = 3'd5;

   typedef logic [1:0] cnt_sel_type;
   localparam cnt_sel_type CNT_HOLD        = 2'd0;
   localparam cnt_sel_type CNT_LEN         = 2'd1;
   localparam cnt_sel_type CNT_LEN_CUR     = 2'd2;
   localparam cnt_sel_type CNT_LEN_CUR_DEC = 2'd3;

   typedef logic [1:0] wr_sel_type;
   localparam wr_sel_type WR_NONE        = 2'd0;
   localparam wr_sel_type WR_BYTE_CUR    = 2'd1;
   localparam wr_sel_type WR_RDATA_CURDEC = 2'd2;
   localparam wr_sel_type WR_HOLD_CUR    = 2'd3;

   typedef logic [2:0] len_op_type;
   localparam len_op_type LEN_HOLD = 3'd0;
   localparam len_op_type LEN_INC  = 3'd1;
   localparam len_op_type LEN_DEC  = 3'd2;
   localparam len_op_type LEN_ZERO = 3'd3;
   localparam len_op_type LEN_CUR  = 3'd4;

   typedef logic [2:0] cur_op_type;
   localparam cur_op_type CUR_HOLD = 3'd0;
   localparam cur_op_type CUR_INC  = 3'd1;
   localparam cur_op_type CUR_DEC  = 3'd2;
   localparam cur_op_type CUR_ZERO = 3'd3;
   localparam cur_op_type CUR_LEN  = 3'd4;

   typedef struct packed {
      logic        byte_load;
      ptr_sel_type ptr_sel;
      cnt_sel_type cnt_sel;
      logic        walk_en;
      logic        walk_rise;
      logic        rd_step;
      logic        hold_load;
      wr_sel_type  wr_sel;
      len_op_type  len_op;
      cur_op_type  cur_op;
      logic        rsp_load;
      event_type   rsp_event;
      logic        rsp_char;
      logic        rsp_last;
   } dp_cmd_type;

   typedef struct packed {
      byte_type rx_byte;
      logic     len_zero;
      logic     cur_zero;
      logic     cur_lt_len;
      logic     len_full;
      logic     cnt_zero;
      logic     slot_free;
   } dp_status_type;

   function automatic key_type decode_normal(input byte_type b);
      key_type k;
      begin
         case (b)
            CH_CR, CH_LF: k = KEY_ENTER;
            CH_CTRL_A:    k = KEY_HOME;
            CH_CTRL_B:    k = KEY_LEFT;
            CH_CTRL_C:    k = KEY_INTR;
            CH_CTRL_D:    k = KEY_CTRLD;
            CH_CTRL_E:    k = KEY_END;
            CH_CTRL_F:    k = KEY_RIGHT;
            CH_BS, CH_DEL: k = KEY_BS;
            CH_CTRL_K:    k = KEY_KILL;
            CH_CTRL_L:    k = KEY_CLEAR;
            CH_CTRL_N:    k = KEY_DOWN;
            CH_CTRL_P:    k = KEY_UP;
            CH_CTRL_R:    k = KEY_REDRAW;
            CH_CTRL_T:    k = KEY_SWAP;
            CH_CTRL_U:    k = KEY_CLEARLINE;
            CH_CTRL_W:    k = KEY_WORD;
            default:      k = (b >= CH_SPACE && b < CH_DEL) ? KEY_CHAR : KEY_NONE;
         endcase
         return k;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/sle_req_if.sv @@
// input channel carrying received terminal bytes
`timescale 1ns / 1ps
`default_nettype none

interface sle_req_if;
   logic               valid;
   logic               ready;
   sle_pkg::byte_type  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/sle_rsp_if.sv @@
// result channel carrying editor events and command readout
`timescale 1ns / 1ps
`default_nettype none

interface sle_rsp_if;
   logic                           valid;
   logic                           ready;
   sle_pkg::event_type             event_code;
   sle_pkg::byte_type              command_char;
   logic [sle_pkg::LEN_W-1:0]      length_now;
   logic [sle_pkg::LEN_W-1:0]      cursor_now;
   logic                           last_of_run;

   modport source (output valid, output event_code, output command_char,
                   output length_now, output cursor_now, output last_of_run,
                   input ready);
   modport sink (input valid, input event_code, input command_char,
                 input length_now, input cursor_now, input last_of_run,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/serial_line_editor_core.sv @@
// top level of the serial line editor
//
// req_ch takes one received terminal byte per beat. rsp_ch gives the
// resulting beats: one event beat for most bytes, or, for Enter on a
// non-empty line, one command beat per stored character, the last one
// flagged by last_of_run.
// A byte is taken only while the state machine is idle, which it enters in the
// cycle after the last result of the previous byte is loaded, so no new byte is
// taken before the last one is through; a plain key goes from S_DECODE to S_EMIT.
// Insert, backspace and delete walk the line store one entry per cycle in
// S_SHIFT, then update length and cursor in S_FIX before S_EMIT; insert and
// backspace move length - cursor entries, delete one fewer.
// Swap steps through S_SWAP_A to S_SWAP_D before S_EMIT; a readout gives one
// character for each pass through S_READ and S_OUT.
// Reset clears length, cursor and the escape state; the line store itself
// is not cleared, no entry beyond the length is ever read.
// The result sits in an output register: while the receiver stalls the next
// byte is still taken and worked on, and its result waits for the register.
`timescale 1ns / 1ps
`default_nettype none

module serial_line_editor_core #(
   parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
   input  wire          clock,
   input  wire          reset,
   sle_req_if.sink      req_ch,
   sle_rsp_if.source    rsp_ch
);

   sle_pkg::dp_cmd_type    cmd;
   sle_pkg::dp_status_type st;
   logic                   req_ready;

   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   sle_datapath #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .rx_byte   (req_ch.rx_byte),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_event (rsp_ch.event_code),
      .rsp_char  (rsp_ch.command_char),
      .rsp_len   (rsp_ch.length_now),
      .rsp_cur   (rsp_ch.cursor_now),
      .rsp_last  (rsp_ch.last_of_run)
   );

   assign req_ch.ready = req_ready;

endmodule

`default_nettype wire

@@ rtl/sle_datapath.sv @@
// line store, length, cursor, walk pointer and result register
`timescale 1ns / 1ps
`default_nettype none

module sle_datapath #(
   parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  sle_pkg::dp_cmd_type            cmd,
   output sle_pkg::dp_status_type         st,
   input  sle_pkg::byte_type              rx_byte,
   input  wire                            rsp_ready,
   output logic                           rsp_valid,
   output sle_pkg::event_type             rsp_event,
   output sle_pkg::byte_type              rsp_char,
   output logic [sle_pkg::LEN_W-1:0]      rsp_len,
   output logic [sle_pkg::LEN_W-1:0]      rsp_cur,
   output logic                           rsp_last
);

   localparam int IDX_W = $clog2(LINE_CAPACITY);
   localparam logic [IDX_W-1:0] FULL_LEN = IDX_W'(LINE_CAPACITY - 1);
   localparam logic [IDX_W-1:0] ONE = IDX_W'(1);

   sle_pkg::byte_type line_mem [LINE_CAPACITY];

   logic [IDX_W-1:0]  len_ff, len_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  wr_dest_ff, wr_dest_in;
   logic              wr_pend_ff, wr_pend_in;
   sle_pkg::byte_type byte_ff, rd_data_ff, hold_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   sle_pkg::event_type rsp_event_ff;
   sle_pkg::byte_type rsp_char_ff;
   logic [sle_pkg::LEN_W-1:0] rsp_len_ff, rsp_cur_ff;
   logic              rsp_last_ff;

   logic              cnt_zero;
   logic              walk_go;
   logic              rd_en;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   sle_pkg::byte_type wr_data;
   logic              slot_free;

   assign cnt_zero  = (cnt_ff == '0);
   assign walk_go   = cmd.walk_en && !cnt_zero;
   assign rd_en     = walk_go || cmd.rd_step;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ptr_in = ptr_ff;
      case (cmd.ptr_sel)
         sle_pkg::PTR_ZERO:    ptr_in = '0;
         sle_pkg::PTR_CUR:     ptr_in = cur_ff;
         sle_pkg::PTR_CUR_INC: ptr_in = cur_ff + ONE;
         sle_pkg::PTR_CUR_DEC: ptr_in = cur_ff - ONE;
         sle_pkg::PTR_LEN_DEC: ptr_in = len_ff - ONE;
         default:              ptr_in = ptr_ff;
      endcase
      if (walk_go) begin
         ptr_in = cmd.walk_rise ? (ptr_ff - ONE) : (ptr_ff + ONE);
      end else if (cmd.rd_step) begin
         ptr_in = ptr_ff + ONE;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      case (cmd.cnt_sel)
         sle_pkg::CNT_LEN:         cnt_in = len_ff;
         sle_pkg::CNT_LEN_CUR:     cnt_in = len_ff - cur_ff;
         sle_pkg::CNT_LEN_CUR_DEC: cnt_in = len_ff - cur_ff - ONE;
         default:                  cnt_in = cnt_ff;
      endcase
      if (rd_en && !cnt_zero) begin
         cnt_in = cnt_ff - ONE;
      end
   end

   assign wr_pend_in = walk_go;
   assign wr_dest_in = cmd.walk_rise ? (ptr_ff + ONE) : (ptr_ff - ONE);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = byte_ff;
      if (wr_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = wr_dest_ff;
         wr_data = rd_data_ff;
      end else begin
         case (cmd.wr_sel)
            sle_pkg::WR_BYTE_CUR: begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = byte_ff;
            end
            sle_pkg::WR_RDATA_CURDEC: begin
               wr_en   = 1'b1;
               wr_addr = cur_ff - ONE;
               wr_data = rd_data_ff;
            end
            sle_pkg::WR_HOLD_CUR: begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = hold_ff;
            end
            default: wr_en = 1'b0;
         endcase
      end
   end

   always_comb begin
      len_in = len_ff;
      case (cmd.len_op)
         sle_pkg::LEN_INC:  len_in = len_ff + ONE;
         sle_pkg::LEN_DEC:  len_in = len_ff - ONE;
         sle_pkg::LEN_ZERO: len_in = '0;
         sle_pkg::LEN_CUR:  len_in = cur_ff;
         default:           len_in = len_ff;
      endcase
   end

   always_comb begin
      cur_in = cur_ff;
      case (cmd.cur_op)
         sle_pkg::CUR_INC:  cur_in = cur_ff + ONE;
         sle_pkg::CUR_DEC:  cur_in = cur_ff - ONE;
         sle_pkg::CUR_ZERO: cur_in = '0;
         sle_pkg::CUR_LEN:  cur_in = len_ff;
         default:           cur_in = cur_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // line store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         cur_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      cnt_ff     <= cnt_in;
      wr_dest_ff <= wr_dest_in;
      if (cmd.byte_load) begin
         byte_ff <= rx_byte;
      end
      if (cmd.hold_load) begin
         hold_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         rsp_event_ff <= cmd.rsp_event;
         rsp_char_ff  <= cmd.rsp_char ? rd_data_ff : '0;
         rsp_len_ff   <= sle_pkg::LEN_W'(len_ff);
         rsp_cur_ff   <= sle_pkg::LEN_W'(cur_ff);
         rsp_last_ff  <= cmd.rsp_last;
      end
   end

   assign st.rx_byte    = byte_ff;
   assign st.len_zero   = (len_ff == '0);
   assign st.cur_zero   = (cur_ff == '0);
   assign st.cur_lt_len = (cur_ff < len_ff);
   assign st.len_full   = (len_ff >= FULL_LEN);
   assign st.cnt_zero   = cnt_zero;
   assign st.slot_free  = slot_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event = rsp_event_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_len   = rsp_len_ff;
   assign rsp_cur   = rsp_cur_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/sle_ctrl.sv @@
// escape decoder and sequencing state machine
`timescale 1ns / 1ps
`default_nettype none

module sle_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  sle_pkg::dp_status_type     st,
   output sle_pkg::dp_cmd_type        cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_SHIFT  = 4'd2;
   localparam logic [3:0] S_FIX    = 4'd3;
   localparam logic [3:0] S_SWAP_A = 4'd4;
   localparam logic [3:0] S_SWAP_B = 4'd5;
   localparam logic [3:0] S_SWAP_C = 4'd6;
   localparam logic [3:0] S_SWAP_D = 4'd7;
   localparam logic [3:0] S_READ   = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;
   localparam logic [3:0] S_EMIT   = 4'd10;

   localparam logic [1:0] PH_NORMAL  = 2'd0;
   localparam logic [1:0] PH_ESC     = 2'd1;
   localparam logic [1:0] PH_BRACKET = 2'd2;
   localparam logic [1:0] PH_TILDE   = 2'd3;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          phase_ff, phase_in;
   sle_pkg::event_type  ev_ff, ev_in;
   sle_pkg::key_type    op_ff, op_in;
   sle_pkg::key_type    key_now;
   logic [1:0]          phase_now;

   // key and escape phase from the latched byte
   always_comb begin
      key_now   = sle_pkg::KEY_NONE;
      phase_now = PH_NORMAL;
      case (phase_ff)
         PH_ESC: begin
            phase_now = (st.rx_byte == sle_pkg::CH_LBRACKET) ? PH_BRACKET : PH_NORMAL;
         end
         PH_BRACKET: begin
            case (st.rx_byte)
               sle_pkg::CH_UPPER_A: key_now = sle_pkg::KEY_UP;
               sle_pkg::CH_UPPER_B: key_now = sle_pkg::KEY_DOWN;
               sle_pkg::CH_UPPER_C: key_now = sle_pkg::KEY_RIGHT;
               sle_pkg::CH_UPPER_D: key_now = sle_pkg::KEY_LEFT;
               sle_pkg::CH_UPPER_H: key_now = sle_pkg::KEY_HOME;
               sle_pkg::CH_UPPER_F: key_now = sle_pkg::KEY_END;
               sle_pkg::CH_DIGIT_1: begin
                  key_now   = sle_pkg::KEY_HOME;
                  phase_now = PH_TILDE;
               end
               sle_pkg::CH_DIGIT_3: begin
                  key_now   = sle_pkg::KEY_DEL;
                  phase_now = PH_TILDE;
               end
               sle_pkg::CH_DIGIT_4: begin
                  key_now   = sle_pkg::KEY_END;
                  phase_now = PH_TILDE;
               end
               default: key_now = sle_pkg::KEY_NONE;
            endcase
         end
         PH_TILDE: begin
            if (st.rx_byte != sle_pkg::CH_TILDE) begin
               key_now   = sle_pkg::decode_normal(st.rx_byte);
               phase_now = (st.rx_byte == sle_pkg::CH_ESC) ? PH_ESC : PH_NORMAL;
            end
         end
         default: begin
            key_now   = sle_pkg::decode_normal(st.rx_byte);
            phase_now = (st.rx_byte == sle_pkg::CH_ESC) ? PH_ESC : PH_NORMAL;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      ev_in    = ev_ff;
      op_in    = op_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.byte_load = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            phase_in = phase_now;
            op_in    = key_now;
            ev_in    = sle_pkg::EV_NONE;
            state_in = S_EMIT;
            case (key_now)
               sle_pkg::KEY_ENTER: begin
                  if (st.len_zero) begin
                     ev_in = sle_pkg::EV_EMPTY;
                  end else begin
                     cmd.ptr_sel = sle_pkg::PTR_ZERO;
                     cmd.cnt_sel = sle_pkg::CNT_LEN;
                     cmd.len_op  = sle_pkg::LEN_ZERO;
                     cmd.cur_op  = sle_pkg::CUR_ZERO;
                     state_in    = S_READ;
                  end
               end
               sle_pkg::KEY_BS: begin
                  if (!st.cur_zero) begin
                     cmd.ptr_sel = sle_pkg::PTR_CUR;
                     cmd.cnt_sel = sle_pkg::CNT_LEN_CUR;
                     ev_in       = sle_pkg::EV_CHANGED;
                     state_in    = S_SHIFT;
                  end
               end
               sle_pkg::KEY_DEL, sle_pkg::KEY_CTRLD: begin
                  if (key_now == sle_pkg::KEY_CTRLD && st.len_zero) begin
                     ev_in = sle_pkg::EV_EOF;
                  end else if (st.cur_lt_len) begin
                     cmd.ptr_sel = sle_pkg::PTR_CUR_INC;
                     cmd.cnt_sel = sle_pkg::CNT_LEN_CUR_DEC;
                     ev_in       = sle_pkg::EV_CHANGED;
                     state_in    = S_SHIFT;
                  end
               end
               sle_pkg::KEY_LEFT: begin
                  if (!st.cur_zero) begin
                     cmd.cur_op = sle_pkg::CUR_DEC;
                     ev_in      = sle_pkg::EV_MOVED;
                  end
               end
               sle_pkg::KEY_RIGHT: begin
                  if (st.cur_lt_len) begin
                     cmd.cur_op = sle_pkg::CUR_INC;
                     ev_in      = sle_pkg::EV_MOVED;
                  end
               end
               sle_pkg::KEY_HOME: begin
                  if (!st.cur_zero) begin
                     cmd.cur_op = sle_pkg::CUR_ZERO;
                     ev_in      = sle_pkg::EV_HOME;
                  end
               end
               sle_pkg::KEY_END: begin
                  if (st.cur_lt_len) begin
                     cmd.cur_op = sle_pkg::CUR_LEN;
                     ev_in      = sle_pkg::EV_END;
                  end
               end
               sle_pkg::KEY_UP:        ev_in = sle_pkg::EV_PREV;
               sle_pkg::KEY_DOWN:      ev_in = sle_pkg::EV_NEXT;
               sle_pkg::KEY_INTR:      ev_in = sle_pkg::EV_INTR;
               sle_pkg::KEY_CLEAR:     ev_in = sle_pkg::EV_CLEAR;
               sle_pkg::KEY_REDRAW:    ev_in = sle_pkg::EV_REDRAW;
               sle_pkg::KEY_WORD:      ev_in = sle_pkg::EV_WORD;
               sle_pkg::KEY_CLEARLINE: ev_in = sle_pkg::EV_CLEARLINE;
               sle_pkg::KEY_KILL: begin
                  if (st.cur_lt_len) begin
                     cmd.len_op = sle_pkg::LEN_CUR;
                     ev_in      = sle_pkg::EV_KILL;
                  end
               end
               sle_pkg::KEY_SWAP: begin
                  if (!st.cur_zero && st.cur_lt_len) begin
                     cmd.ptr_sel = sle_pkg::PTR_CUR_DEC;
                     ev_in       = sle_pkg::EV_SWAP;
                     state_in    = S_SWAP_A;
                  end
               end
               sle_pkg::KEY_CHAR: begin
                  if (!st.len_full) begin
                     cmd.ptr_sel = sle_pkg::PTR_LEN_DEC;
                     cmd.cnt_sel = sle_pkg::CNT_LEN_CUR;
                     ev_in       = sle_pkg::EV_CHANGED;
                     state_in    = S_SHIFT;
                  end
               end
               default: ev_in = sle_pkg::EV_NONE;
            endcase
         end
         S_SHIFT: begin
            cmd.walk_en   = 1'b1;
            cmd.walk_rise = (op_ff == sle_pkg::KEY_CHAR);
            if (st.cnt_zero) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            state_in = S_EMIT;
            case (op_ff)
               sle_pkg::KEY_CHAR: begin
                  cmd.wr_sel = sle_pkg::WR_BYTE_CUR;
                  cmd.len_op = sle_pkg::LEN_INC;
                  cmd.cur_op = sle_pkg::CUR_INC;
               end
               sle_pkg::KEY_BS: begin
                  cmd.len_op = sle_pkg::LEN_DEC;
                  cmd.cur_op = sle_pkg::CUR_DEC;
               end
               default: cmd.len_op = sle_pkg::LEN_DEC;
            endcase
         end
         S_SWAP_A: begin
            cmd.rd_step = 1'b1;
            state_in    = S_SWAP_B;
         end
         S_SWAP_B: begin
            cmd.rd_step   = 1'b1;
            cmd.hold_load = 1'b1;
            state_in      = S_SWAP_C;
         end
         S_SWAP_C: begin
            cmd.wr_sel = sle_pkg::WR_RDATA_CURDEC;
            state_in   = S_SWAP_D;
         end
         S_SWAP_D: begin
            cmd.wr_sel = sle_pkg::WR_HOLD_CUR;
            cmd.cur_op = sle_pkg::CUR_INC;
            state_in   = S_EMIT;
         end
         S_READ: begin
            cmd.rd_step = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (st.slot_free) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_event = sle_pkg::EV_COMMAND;
               cmd.rsp_char  = 1'b1;
               cmd.rsp_last  = st.cnt_zero;
               state_in      = st.cnt_zero ? S_IDLE : S_READ;
            end
         end
         S_EMIT: begin
            if (st.slot_free) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_event = ev_ff;
               cmd.rsp_last  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_NORMAL;
         ev_ff    <= sle_pkg::EV_NONE;
         op_ff    <= sle_pkg::KEY_NONE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         ev_ff    <= ev_in;
         op_ff    <= op_in;
      end
   end

endmodule

`default_nettype wire
